// File: sv/rsca_pkg.sv
// ----------------------------------------------------------------------------
// rsca_pkg
// Shared types and constants of the receive sequence check and ack coalescer.
// ----------------------------------------------------------------------------
package rsca_pkg;

  // Defaults of the top-level parameters.
  localparam int ID_BITS_DEF    = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int ID_W    = 32;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 16;
  localparam int BYTES_W = 32;
  localparam int TICKS_W = 32;
  localparam int TIMER_W = 16;
  localparam int WIN_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 88;
  localparam int TUSER_W   = 2;

  // Result slots per input item (ack, resend request, verdict) and queue size.
  localparam int NSLOT   = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    MODE_PACKET = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_RESYNC = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_RESEND  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE     = 3'd0,
    REG_ACK_MIN_COUNT   = 3'd1,
    REG_ACK_MIN_BYTES   = 3'd2,
    REG_IDLE_ACK_TICKS  = 3'd3,
    REG_ACK_DELAY_TICKS = 3'd4,
    REG_PASS_THROUGH    = 3'd5,
    REG_ACK_PATH_READY  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_size;
    logic [CNT_W-1:0]   ack_min_count;
    logic [BYTES_W-1:0] ack_min_bytes;
    logic [TIMER_W-1:0] idle_ack_ticks;
    logic [TIMER_W-1:0] ack_delay_ticks;
    logic               pass_through;
    logic               ack_path_ready;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic              accepted;
    logic [ID_W-1:0]   ack_last_id;
    logic [CNT_W-1:0]  ack_count;
    logic [ID_W-1:0]   resend_from_id;
    logic              last;
  } result_t;

  // Results produced by one item, slot 0 ack, slot 1 resend, slot 2 verdict.
  typedef struct packed {
    logic    [NSLOT-1:0] valid;
    result_t [NSLOT-1:0] item;
  } push_t;

endpackage

// File: sv/rsca_cfg.sv
// ----------------------------------------------------------------------------
// rsca_cfg
// Configuration register file, written through an index and data channel.
// ----------------------------------------------------------------------------
module rsca_cfg
  import rsca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size     <= WIN_W'(1024);
      cfg.ack_min_count   <= CNT_W'(16);
      cfg.ack_min_bytes   <= BYTES_W'(65536);
      cfg.idle_ack_ticks  <= TIMER_W'(100);
      cfg.ack_delay_ticks <= TIMER_W'(50);
      cfg.pass_through    <= 1'b0;
      cfg.ack_path_ready  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW_SIZE:     cfg.window_size     <= cfg_data[WIN_W-1:0];
        REG_ACK_MIN_COUNT:   cfg.ack_min_count   <= cfg_data[CNT_W-1:0];
        REG_ACK_MIN_BYTES:   cfg.ack_min_bytes   <= cfg_data[BYTES_W-1:0];
        REG_IDLE_ACK_TICKS:  cfg.idle_ack_ticks  <= cfg_data[TIMER_W-1:0];
        REG_ACK_DELAY_TICKS: cfg.ack_delay_ticks <= cfg_data[TIMER_W-1:0];
        REG_PASS_THROUGH:    cfg.pass_through    <= cfg_data[0];
        REG_ACK_PATH_READY:  cfg.ack_path_ready  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/rsca_core.sv
// ----------------------------------------------------------------------------
// rsca_core
// Receive state and the single-pass step that turns one item into results.
// ----------------------------------------------------------------------------
module rsca_core
  import rsca_pkg::*;
#(
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mode_t            mode,
  input  logic [ID_W-1:0]  pkt_id,
  input  logic [LEN_W-1:0] pkt_len,
  input  cfg_t             cfg,
  output push_t            push
);

  logic [ID_BITS-1:0]    expected_id, expected_id_next;
  logic [ID_BITS-1:0]    last_accepted_id, last_accepted_id_next;
  logic [COUNT_BITS-1:0] pending_count, pending_count_next;
  logic [BYTES_W-1:0]    pending_bytes, pending_bytes_next;
  logic [TICKS_W-1:0]    ticks_since_accept, ticks_since_accept_next;
  logic                  accept_seen, accept_seen_next;
  logic [TIMER_W-1:0]    ack_timer_left, ack_timer_left_next;
  logic                  ack_timer_on, ack_timer_on_next;

  logic [ID_BITS+ID_W-1:0]       id_wide;
  logic [ID_BITS-1:0]            id;
  logic [ID_BITS-1:0]            ahead, behind, id_inc, id_after;
  logic [ID_BITS+WIN_W-1:0]      ahead_x, behind_x, win_x;
  logic                          resend;
  logic                          ack_due;
  logic [COUNT_BITS-1:0]         count_inc;
  logic [BYTES_W:0]              bytes_sum;
  logic [BYTES_W-1:0]            bytes_inc;
  logic [COUNT_BITS+CNT_W-1:0]   count_x, min_count_x;
  logic                          fire;
  logic                          ack_v, res_v, ver_v, ver_acc;
  logic [ID_BITS-1:0]            ack_id_src;
  logic [COUNT_BITS-1:0]         ack_cnt_src;
  logic [ID_BITS+ID_W-1:0]       ack_id_x, exp_id_x;
  logic [COUNT_BITS+CNT_W-1:0]   ack_cnt_x;

  // Arrival id reduced to the id width.
  assign id_wide = {{ID_BITS{1'b0}}, pkt_id};
  assign id      = id_wide[ID_BITS-1:0];

  // Window check: ahead within the window, or behind by more than it.
  assign ahead    = id - expected_id;
  assign behind   = expected_id - id;
  assign ahead_x  = {{WIN_W{1'b0}}, ahead};
  assign behind_x = {{WIN_W{1'b0}}, behind};
  assign win_x    = {{ID_BITS{1'b0}}, cfg.window_size};
  assign resend   = (id > expected_id) ? (ahead_x <= win_x) : (behind_x > win_x);

  assign ack_due = !accept_seen ||
                   (ticks_since_accept >= {{(TICKS_W-TIMER_W){1'b0}}, cfg.idle_ack_ticks});

  // Next expected id wraps and skips zero.
  assign id_inc   = id + ID_BITS'(1);
  assign id_after = (id_inc == '0) ? ID_BITS'(1) : id_inc;

  // Saturating pending totals.
  assign count_inc = (&pending_count) ? pending_count : pending_count + COUNT_BITS'(1);
  assign bytes_sum = {1'b0, pending_bytes} + {{(BYTES_W+1-LEN_W){1'b0}}, pkt_len};
  assign bytes_inc = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];

  assign count_x     = {{CNT_W{1'b0}}, count_inc};
  assign min_count_x = {{COUNT_BITS{1'b0}}, cfg.ack_min_count};
  assign fire = (count_x >= min_count_x) || (bytes_inc >= cfg.ack_min_bytes) || ack_due;

  always_comb begin
    expected_id_next        = expected_id;
    last_accepted_id_next   = last_accepted_id;
    pending_count_next      = pending_count;
    pending_bytes_next      = pending_bytes;
    ticks_since_accept_next = ticks_since_accept;
    accept_seen_next        = accept_seen;
    ack_timer_left_next     = ack_timer_left;
    ack_timer_on_next       = ack_timer_on;
    ack_v       = 1'b0;
    res_v       = 1'b0;
    ver_v       = 1'b0;
    ver_acc     = 1'b0;
    ack_id_src  = last_accepted_id;
    ack_cnt_src = pending_count;
    if (step) begin
      case (mode)
        MODE_PACKET: begin
          ver_v = 1'b1;
          if (cfg.pass_through) begin
            ver_acc = 1'b1;
          end else if (id != expected_id) begin
            // Out of order: flush what is pending, then maybe ask for a resend.
            if (pending_count != '0) begin
              ack_timer_on_next   = 1'b0;
              ack_timer_left_next = '0;
              if (cfg.ack_path_ready) begin
                ack_v              = 1'b1;
                pending_count_next = '0;
                pending_bytes_next = '0;
              end
            end
            res_v = resend && cfg.ack_path_ready;
          end else begin
            ver_acc                 = 1'b1;
            ticks_since_accept_next = '0;
            accept_seen_next        = 1'b1;
            last_accepted_id_next   = id;
            expected_id_next        = id_after;
            if ((pending_count == '0) && !ack_due) begin
              ack_timer_on_next   = 1'b1;
              ack_timer_left_next = cfg.ack_delay_ticks;
            end
            pending_count_next = count_inc;
            pending_bytes_next = bytes_inc;
            ack_id_src         = id;
            ack_cnt_src        = count_inc;
            if (fire) begin
              ack_timer_on_next   = 1'b0;
              ack_timer_left_next = '0;
              if (cfg.ack_path_ready) begin
                ack_v              = 1'b1;
                pending_count_next = '0;
                pending_bytes_next = '0;
              end
            end
          end
        end
        MODE_TICK: begin
          if (!(&ticks_since_accept)) begin
            ticks_since_accept_next = ticks_since_accept + TICKS_W'(1);
          end
          if (ack_timer_on) begin
            if (ack_timer_left <= TIMER_W'(1)) begin
              ack_timer_on_next   = 1'b0;
              ack_timer_left_next = '0;
              if (cfg.ack_path_ready) begin
                ack_v              = 1'b1;
                pending_count_next = '0;
                pending_bytes_next = '0;
              end
            end else begin
              ack_timer_left_next = ack_timer_left - TIMER_W'(1);
            end
          end
        end
        MODE_RESYNC: begin
          expected_id_next        = ID_BITS'(1);
          last_accepted_id_next   = '0;
          pending_count_next      = '0;
          pending_bytes_next      = '0;
          ticks_since_accept_next = '0;
          accept_seen_next        = 1'b0;
          ack_timer_left_next     = '0;
          ack_timer_on_next       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign ack_id_x  = {{ID_W{1'b0}}, ack_id_src};
  assign exp_id_x  = {{ID_W{1'b0}}, expected_id};
  assign ack_cnt_x = {{CNT_W{1'b0}}, ack_cnt_src};

  always_comb begin
    push.valid = {ver_v, res_v, ack_v};

    push.item[0].kind           = KIND_ACK;
    push.item[0].accepted       = 1'b0;
    push.item[0].ack_last_id    = ack_id_x[ID_W-1:0];
    push.item[0].ack_count      = ack_cnt_x[CNT_W-1:0];
    push.item[0].resend_from_id = '0;
    push.item[0].last           = !res_v && !ver_v;

    push.item[1].kind           = KIND_RESEND;
    push.item[1].accepted       = 1'b0;
    push.item[1].ack_last_id    = '0;
    push.item[1].ack_count      = '0;
    push.item[1].resend_from_id = exp_id_x[ID_W-1:0];
    push.item[1].last           = !ver_v;

    push.item[2].kind           = KIND_VERDICT;
    push.item[2].accepted       = ver_acc;
    push.item[2].ack_last_id    = '0;
    push.item[2].ack_count      = '0;
    push.item[2].resend_from_id = '0;
    push.item[2].last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id        <= ID_BITS'(1);
      last_accepted_id   <= '0;
      pending_count      <= '0;
      pending_bytes      <= '0;
      ticks_since_accept <= '0;
      accept_seen        <= 1'b0;
      ack_timer_left     <= '0;
      ack_timer_on       <= 1'b0;
    end else begin
      expected_id        <= expected_id_next;
      last_accepted_id   <= last_accepted_id_next;
      pending_count      <= pending_count_next;
      pending_bytes      <= pending_bytes_next;
      ticks_since_accept <= ticks_since_accept_next;
      accept_seen        <= accept_seen_next;
      ack_timer_left     <= ack_timer_left_next;
      ack_timer_on       <= ack_timer_on_next;
    end
  end

  // The expected id skips zero, so it can never hold zero.
  a_exp_nonzero: assert property (@(posedge clk) disable iff (rst)
    expected_id != '0)
    else $error("expected id reached zero");

  // Of the results of one item, exactly one carries the final mark.
  a_one_last: assert property (@(posedge clk) disable iff (rst)
    (step && (push.valid != '0)) |->
      $onehot(push.valid & {push.item[2].last, push.item[1].last, push.item[0].last}))
    else $error("final mark not unique among results of one item");

  // A sent acknowledgment leaves nothing pending.
  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    (step && push.valid[0]) |=> (pending_count == '0) && (pending_bytes == '0))
    else $error("pending totals kept after an acknowledgment");

  // A resync brings back the reset receive state.
  a_resync: assert property (@(posedge clk) disable iff (rst)
    (step && (mode == MODE_RESYNC)) |=>
      (expected_id == ID_BITS'(1)) && !ack_timer_on && !accept_seen)
    else $error("resync left receive state behind");

endmodule

// File: sv/rsca_outq.sv
// ----------------------------------------------------------------------------
// rsca_outq
// Result queue: takes up to three results per cycle, hands out one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module rsca_outq
  import rsca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t head
);

  result_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_AW:0]    count;
  logic [Q_AW-1:0]  off [NSLOT];
  logic [Q_AW:0]    push_n;
  logic             pop;

  // Valid results are packed together in slot order.
  always_comb begin
    off[0] = '0;
    off[1] = Q_AW'(push.valid[0]);
    off[2] = Q_AW'(push.valid[0]) + Q_AW'(push.valid[1]);
    push_n = (Q_AW+1)'(push.valid[0]) + (Q_AW+1)'(push.valid[1]) +
             (Q_AW+1)'(push.valid[2]);
  end

  assign m_valid = (count != '0);
  assign head    = mem[rd_ptr];
  assign pop     = m_valid && m_ready;
  assign room    = (count <= (Q_AW+1)'(Q_DEPTH - NSLOT));

  always_ff @(posedge clk) begin
    for (int j = 0; j < NSLOT; j++) begin
      if (push.valid[j]) begin
        mem[wr_ptr + off[j]] <= push.item[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[Q_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      count <= count + push_n - (Q_AW+1)'(pop);
    end
  end

  // Results are only pushed when they fit.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.valid != '0) |-> ({1'b0, count} + {1'b0, push_n}) <= (Q_AW+2)'(Q_DEPTH))
    else $error("result queue overflow");

  // Empty and full both meet with equal pointers.
  a_ptr_empty: assert property (@(posedge clk) disable iff (rst)
    ((count == '0) || (count == (Q_AW+1)'(Q_DEPTH))) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill count");

  // A full queue never offers room for another item.
  a_room: assert property (@(posedge clk) disable iff (rst)
    room |-> (count <= (Q_AW+1)'(Q_DEPTH - NSLOT)) && (count != (Q_AW+1)'(Q_DEPTH)))
    else $error("room offered while queue lacks space");

endmodule

// File: sv/rx_sequence_check_ack_coalescer.sv
// ----------------------------------------------------------------------------
// rx_sequence_check_ack_coalescer
// Receive-side sequence check with cumulative, coalesced acknowledgments.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Carries
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_tvalid/s_tready  | packet, tick or resync event
//  m_       | out       | m_tvalid/m_tready  | verdict, ack or resend request
//  cfg_     | in        | cfg_valid/cfg_ready| register index and write data
//
//  An event is held in an input register, evaluated against the receive
//  state once the queue has room, and its results (none to three) land in
//  a four-entry result queue, whose head is shown on m_ once written.
//  A new event is taken every cycle while the queue has room for three
//  results, so the sustained pace is one event per cycle when each event
//  yields at most one result and m_tready stays high; when each packet
//  yields an ack, a resend request and a verdict, the single-result output
//  port, which must hand out all three, sets the pace.
//  Reset is synchronous; it restores register defaults and clears the
//  receive state at once. A stall on m_tready backs up into s_tready once
//  the queue holds two or more results and the input register is occupied.
// ----------------------------------------------------------------------------
module rx_sequence_check_ack_coalescer
  import rsca_pkg::*;
#(
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input events.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // pkt_id[31:0], pkt_len[47:32]
  input  logic [TUSER_W-1:0]    s_tuser,   // mode[1:0]
  // Results.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // accepted[0], ack_last_id[32:1],
                                           // ack_count[48:33],
                                           // resend_from_id[80:49], zero[87:81]
  output logic [TUSER_W-1:0]    m_tuser,   // kind[1:0]
  output logic                  m_tlast,   // last
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  push_t            push;
  result_t          head;
  logic             room;
  logic             step;

  // Input register holding one event until the queue can take its results.
  logic             in_vld;
  logic [1:0]       in_mode;
  logic [ID_W-1:0]  in_id;
  logic [LEN_W-1:0] in_len;

  // The event is evaluated once the queue has space for all its results.
  assign step     = in_vld && room;
  assign s_tready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_id   <= s_tdata[ID_W-1:0];
      in_len  <= s_tdata[ID_W+LEN_W-1:ID_W];
    end
  end

  rsca_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsca_core #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .mode    (mode_t'(in_mode)),
    .pkt_id  (in_id),
    .pkt_len (in_len),
    .cfg     (cfg),
    .push    (push)
  );

  rsca_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .head    (head)
  );

  // Result fields packed from the lowest bit up, padded to whole bytes.
  assign m_tdata = {{(M_TDATA_W-1-ID_W-CNT_W-ID_W){1'b0}}, head.resend_from_id,
                    head.ack_count, head.ack_last_id, head.accepted};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

// File: test/rx_sequence_check_ack_coalescer_test.sv
// ----------------------------------------------------------------------------
// rx_sequence_check_ack_coalescer_test
// Self-checking bench for the receive sequence check and ack coalescer: it
// drives packet, tick and resync events, predicts the verdicts, acks and
// resend requests, and compares every result as it leaves the block.
// ----------------------------------------------------------------------------
module rx_sequence_check_ack_coalescer_test;
  import rsca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names the three used modes. The fourth code is ignored by the
  // block, and it gets a name here so that it can be sent on purpose.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles allowed after the last result, so that an event that yields
  // no result (a tick, a resync) has left the input register and evaluation
  // stage before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // pkt_id[31:0], pkt_len[47:32]
  logic [TUSER_W-1:0]    s_tuser = '0;   // mode[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // accepted[0], ack_last_id[32:1],
                                         // ack_count[48:33],
                                         // resend_from_id[80:49], zero[87:81]
  logic [TUSER_W-1:0]    m_tuser;        // kind[1:0]
  logic                  m_tlast;        // last
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rx_sequence_check_ack_coalescer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Receiver model. It mirrors the register file and the receive state of the
  // block and turns each event into the results the block must produce.
  // ---------------------------------------------------------------------------
  cfg_t        regs;
  logic [31:0] rx_expected_id;
  logic [31:0] rx_last_id;
  logic [15:0] rx_unacked;
  logic [31:0] rx_unacked_bytes;
  logic [31:0] rx_idle_ticks;
  logic        rx_seen;
  logic [15:0] rx_timer_left;
  logic        rx_timer_on;

  // Results predicted but not yet seen on the output, oldest first.
  result_t expected_out[$];

  int mismatches = 0;
  int events_in = 0;
  int results_out = 0;
  int acks_out = 0;
  int resends_out = 0;
  int settings_used = 0;
  bit gaps_on = 1'b1;
  int sink_wait = 0;
  int quiet_cycles = 0;

  function automatic void clear_receive_state();
    rx_expected_id   = 32'd1;
    rx_last_id       = '0;
    rx_unacked       = '0;
    rx_unacked_bytes = '0;
    rx_idle_ticks    = '0;
    rx_seen          = 1'b0;
    rx_timer_left    = '0;
    rx_timer_on      = 1'b0;
  endfunction

  function automatic void load_default_regs();
    regs.window_size     = 16'd1024;
    regs.ack_min_count   = 16'd16;
    regs.ack_min_bytes   = 32'd65536;
    regs.idle_ack_ticks  = 16'd100;
    regs.ack_delay_ticks = 16'd50;
    regs.pass_through    = 1'b0;
    regs.ack_path_ready  = 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      REG_WINDOW_SIZE:     regs.window_size     = value[15:0];
      REG_ACK_MIN_COUNT:   regs.ack_min_count   = value[15:0];
      REG_ACK_MIN_BYTES:   regs.ack_min_bytes   = value;
      REG_IDLE_ACK_TICKS:  regs.idle_ack_ticks  = value[15:0];
      REG_ACK_DELAY_TICKS: regs.ack_delay_ticks = value[15:0];
      REG_PASS_THROUGH:    regs.pass_through    = value[0];
      REG_ACK_PATH_READY:  regs.ack_path_ready  = value[0];
      default: ;
    endcase
  endfunction

  function automatic void expect_result(kind_t k, logic acc, logic [31:0] lid,
                                        logic [15:0] cnt, logic [31:0] rid);
    result_t r;
    r.kind           = k;
    r.accepted       = acc;
    r.ack_last_id    = lid;
    r.ack_count      = cnt;
    r.resend_from_id = rid;
    r.last           = 1'b0;
    expected_out.push_back(r);
  endfunction

  // Every ack attempt stops the delayed-ack timer. Without a return path the
  // pending count and bytes stay where they are.
  function automatic void attempt_ack();
    rx_timer_on   = 1'b0;
    rx_timer_left = '0;
    if (!regs.ack_path_ready) return;
    expect_result(KIND_ACK, 1'b0, rx_last_id, rx_unacked, '0);
    rx_unacked       = '0;
    rx_unacked_bytes = '0;
  endfunction

  function automatic void predict_event(logic [1:0] mode, logic [31:0] id, logic [15:0] len);
    int          first;
    logic        ack_due;
    logic        resend;
    logic [32:0] byte_sum;
    first = expected_out.size();
    case (mode)
      MODE_PACKET: begin
        if (regs.pass_through) begin
          // An intermediate hop takes everything and keeps no state.
          expect_result(KIND_VERDICT, 1'b1, '0, '0, '0);
        end else if (id != rx_expected_id) begin
          // Out of order: flush what is pending, then decide on a resend.
          if (rx_unacked != 0) attempt_ack();
          if (id > rx_expected_id) begin
            resend = (id - rx_expected_id) <= {16'd0, regs.window_size};
          end else begin
            resend = (rx_expected_id - id) > {16'd0, regs.window_size};
          end
          if (resend && regs.ack_path_ready) begin
            expect_result(KIND_RESEND, 1'b0, '0, '0, rx_expected_id);
          end
          expect_result(KIND_VERDICT, 1'b0, '0, '0, '0);
        end else begin
          ack_due = !rx_seen || (rx_idle_ticks >= {16'd0, regs.idle_ack_ticks});
          rx_idle_ticks  = '0;
          rx_seen        = 1'b1;
          rx_last_id     = id;
          rx_expected_id = id + 32'd1;
          if (rx_expected_id == 0) rx_expected_id = 32'd1;
          // The timer starts with the first packet of a new pending batch.
          if (rx_unacked == 0 && !ack_due) begin
            rx_timer_on   = 1'b1;
            rx_timer_left = regs.ack_delay_ticks;
          end
          if (rx_unacked != 16'hFFFF) rx_unacked++;
          byte_sum = {1'b0, rx_unacked_bytes} + {17'd0, len};
          rx_unacked_bytes = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
          if (rx_unacked >= regs.ack_min_count || rx_unacked_bytes >= regs.ack_min_bytes ||
              ack_due) begin
            attempt_ack();
          end
          expect_result(KIND_VERDICT, 1'b1, '0, '0, '0);
        end
      end
      MODE_TICK: begin
        if (rx_idle_ticks != 32'hFFFF_FFFF) rx_idle_ticks++;
        if (rx_timer_on) begin
          if (rx_timer_left <= 16'd1) attempt_ack();
          else rx_timer_left--;
        end
      end
      MODE_RESYNC: clear_receive_state();
      default: ;
    endcase
    if (expected_out.size() > first) expected_out[expected_out.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    result_t got;
    got.kind           = kind_t'(m_tuser);
    got.accepted       = m_tdata[0];
    got.ack_last_id    = m_tdata[32:1];
    got.ack_count      = m_tdata[48:33];
    got.resend_from_id = m_tdata[80:49];
    got.last           = m_tlast;
    results_out++;
    if (got.kind == KIND_ACK) acks_out++;
    if (got.kind == KIND_RESEND) resends_out++;
    if (expected_out.size() == 0) begin
      $error("unexpected result: kind %0d with nothing expected", m_tuser);
      mismatches++;
      return;
    end
    want = expected_out.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("accepted", want.accepted, got.accepted);
    check_field("ack_last_id", want.ack_last_id, got.ack_last_id);
    check_field("ack_count", want.ack_count, got.ack_count);
    check_field("resend_from_id", want.resend_from_id, got.resend_from_id);
    check_field("last", want.last, got.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers update, so the values seen are those of the transaction itself.
  // A result always trails its event through the input register and queue,
  // so the order of the three checks below within one edge does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        events_in++;
        predict_event(s_tuser, s_tdata[31:0], s_tdata[47:32]);
      end
      if (m_tvalid && m_tready) begin
        check_result();
        sink_wait = gaps_on ? $urandom_range(0, 4) : 0;
      end
    end
  end

  // The result side holds ready low for a freshly drawn number of cycles after
  // each transaction it takes.
  always @(negedge clk) begin
    m_tready = (sink_wait == 0);
    if (sink_wait > 0) sink_wait--;
  end

  // Watchdog: a hung handshake anywhere ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_out.size());
      $display("[rx_sequence_check_ack_coalescer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Sends one event. Valid stays high when the next event follows with no gap,
  // so it is only ever lowered when a gap is drawn or the stream pauses.
  task automatic send_event(input logic [1:0] mode, input logic [31:0] id,
                            input logic [15:0] len);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  = mode;
    s_tdata  = {len, id};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stops the event stream and waits until every predicted result is out and
  // the block has had time to finish events that yield nothing.
  task automatic wait_quiet();
    s_tvalid = 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all seven registers. Only called while the block is idle.
  task automatic set_config(input cfg_t c);
    logic [31:0] value;
    for (int i = REG_WINDOW_SIZE; i <= REG_ACK_PATH_READY; i++) begin
      case (reg_idx_t'(i))
        REG_WINDOW_SIZE:     value = {16'd0, c.window_size};
        REG_ACK_MIN_COUNT:   value = {16'd0, c.ack_min_count};
        REG_ACK_MIN_BYTES:   value = c.ack_min_bytes;
        REG_IDLE_ACK_TICKS:  value = {16'd0, c.idle_ack_ticks};
        REG_ACK_DELAY_TICKS: value = {16'd0, c.ack_delay_ticks};
        REG_PASS_THROUGH:    value = {31'd0, c.pass_through};
        REG_ACK_PATH_READY:  value = {31'd0, c.ack_path_ready};
        default:             value = '0;
      endcase
      cfg_index = CFG_IDX_W'(i);
      cfg_data  = value;
      cfg_valid = 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // Small thresholds so that every ack trigger fires often.
  function automatic cfg_t small_thresholds();
    cfg_t c;
    c.window_size     = 16'($urandom_range(1, 32));
    c.ack_min_count   = 16'($urandom_range(1, 6));
    c.ack_min_bytes   = 32'($urandom_range(0, 6000));
    c.idle_ack_ticks  = 16'($urandom_range(0, 8));
    c.ack_delay_ticks = 16'($urandom_range(1, 5));
    c.pass_through    = 1'b0;
    c.ack_path_ready  = 1'b1;
    return c;
  endfunction

  // One random event. Most are in-order packets so that the pending batch,
  // the timer and the thresholds all get exercised; the rest are packets ahead,
  // behind or anywhere, ticks and the odd resync.
  task automatic send_random_event();
    int          pick;
    int          span;
    logic [31:0] id;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    span = (regs.window_size == 0) ? 1 : int'(regs.window_size);
    len  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    if (pick < 55) id = rx_expected_id;
    else if (pick < 65) id = rx_expected_id + $urandom_range(1, span);
    else if (pick < 70) id = rx_expected_id + span + $urandom_range(1, 1000);
    else if (pick < 76) id = rx_expected_id - $urandom_range(1, 4);
    else if (pick < 79) id = $urandom;
    else id = rx_expected_id - span - $urandom_range(1, 50);
    if (pick < 81) send_event(MODE_PACKET, id, len);
    else if (pick < 98) send_event(MODE_TICK, $urandom, 16'($urandom));
    else send_event(MODE_RESYNC, $urandom, 16'($urandom));
  endtask

  task automatic run_random_events(input int count);
    repeat (count) send_random_event();
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // A hand-built walk through every trigger and every out-of-order case: the
  // first accept, the byte and count thresholds, a timer with a zero period,
  // the window edge, behind within and beyond the window, the idle gap, the
  // ignored mode and a resync.
  task automatic test_directed_walk();
    cfg_t c;
    c.window_size     = 16'd4;
    c.ack_min_count   = 16'd3;
    c.ack_min_bytes   = 32'd5000;
    c.idle_ack_ticks  = 16'd3;
    c.ack_delay_ticks = 16'd0;
    c.pass_through    = 1'b0;
    c.ack_path_ready  = 1'b1;
    set_config(c);
    send_event(MODE_PACKET, rx_expected_id, 16'd0);          // first accept acks at once
    send_event(MODE_PACKET, rx_expected_id, 16'hFFFF);       // byte threshold
    send_event(MODE_PACKET, rx_expected_id, 16'd10);         // starts the timer
    send_event(MODE_TICK, 32'd0, 16'd0);                     // zero period expires now
    send_event(MODE_PACKET, rx_expected_id, 16'd1);
    send_event(MODE_PACKET, rx_expected_id, 16'd1);
    send_event(MODE_PACKET, rx_expected_id, 16'd1);          // count threshold
    send_event(MODE_PACKET, rx_expected_id + 32'd4, 16'd0);  // ahead by exactly the window
    send_event(MODE_PACKET, rx_expected_id + 32'd5, 16'd0);  // ahead beyond the window
    send_event(MODE_PACKET, rx_expected_id, 16'd7);          // leaves one pending
    send_event(MODE_PACKET, rx_expected_id + 32'd1, 16'd0);  // flush, resend and verdict
    send_event(MODE_PACKET, rx_expected_id - 32'd1, 16'd0);  // duplicate, within window
    send_event(MODE_PACKET, 32'd0, 16'd0);                   // far behind
    send_event(MODE_PACKET, 32'hFFFF_FFFF, 16'hFFFF);        // far ahead
    repeat (4) send_event(MODE_TICK, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(MODE_PACKET, rx_expected_id, 16'd3);          // idle gap forces an ack
    send_event(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);        // ignored
    send_event(MODE_RESYNC, 32'd0, 16'd0);
    send_event(MODE_PACKET, 32'd1, 16'hFFFF);                // first accept after resync
    send_event(MODE_PACKET, rx_expected_id, 16'd0);
    wait_quiet();
  endtask

  task automatic test_random_small_thresholds();
    repeat (2) begin
      set_config(small_thresholds());
      run_random_events(40);
    end
  endtask

  // Without a return path nothing but verdicts leaves the block and pending
  // work piles up; the tests that follow turn the path back on.
  task automatic test_random_no_return_path();
    cfg_t c;
    c = small_thresholds();
    c.ack_path_ready = 1'b0;
    set_config(c);
    run_random_events(30);
  endtask

  task automatic test_random_pass_through();
    cfg_t c;
    c = small_thresholds();
    c.pass_through = 1'b1;
    set_config(c);
    run_random_events(20);
  endtask

  // Largest and then very small settings of the window and ack registers.
  task automatic test_random_extremes();
    cfg_t c;
    c.window_size     = 16'hFFFF;
    c.ack_min_count   = 16'hFFFF;
    c.ack_min_bytes   = 32'hFFFF_FFFF;
    c.idle_ack_ticks  = 16'hFFFF;
    c.ack_delay_ticks = 16'hFFFF;
    c.pass_through    = 1'b0;
    c.ack_path_ready  = 1'b1;
    set_config(c);
    run_random_events(25);
    c.window_size     = 16'd1;
    c.ack_min_count   = 16'd1;
    c.ack_min_bytes   = 32'd0;
    c.idle_ack_ticks  = 16'd0;
    c.ack_delay_ticks = 16'd1;
    set_config(c);
    run_random_events(25);
  endtask

  // Back-to-back events with the result side always ready.
  task automatic test_random_full_rate();
    gaps_on = 1'b0;
    set_config(small_thresholds());
    run_random_events(40);
    gaps_on = 1'b1;
  endtask

  // With no return path and thresholds out of reach, the pending count and
  // bytes pile up; the out-of-order packet that follows once the path is back
  // must report the whole count.
  task automatic test_pending_pileup();
    cfg_t c;
    c.window_size     = 16'd16;
    c.ack_min_count   = 16'hFFFF;
    c.ack_min_bytes   = 32'hFFFF_FFFF;
    c.idle_ack_ticks  = 16'hFFFF;
    c.ack_delay_ticks = 16'hFFFF;
    c.pass_through    = 1'b0;
    c.ack_path_ready  = 1'b0;
    gaps_on = 1'b0;
    set_config(c);
    send_event(MODE_RESYNC, 32'd0, 16'd0);
    repeat (20) send_event(MODE_PACKET, rx_expected_id, 16'hFFFF);
    wait_quiet();
    c.ack_path_ready = 1'b1;
    set_config(c);
    send_event(MODE_PACKET, rx_expected_id + 32'd2, 16'd0);
    send_event(MODE_PACKET, rx_expected_id, 16'd0);
    wait_quiet();
    gaps_on = 1'b1;
  endtask

  initial begin
    load_default_regs();
    clear_receive_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed_walk();
    test_random_small_thresholds();
    test_random_no_return_path();
    test_random_pass_through();
    test_random_extremes();
    test_random_full_rate();
    test_pending_pileup();

    $display("Covered %0d events across %0d register settings: %0d results checked,",
             events_in, settings_used, results_out);
    $display("including %0d acknowledgments and %0d resend requests.", acks_out, resends_out);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("[rx_sequence_check_ack_coalescer] OK");
    end else begin
      $display("[rx_sequence_check_ack_coalescer] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rsca_pkg.sv
sv/rsca_cfg.sv
sv/rsca_core.sv
sv/rsca_outq.sv
sv/rx_sequence_check_ack_coalescer.sv
test/rx_sequence_check_ack_coalescer_test.sv
